// ===== design/rtpsd_pkg.sv =====
// Shared types and constants for the RTPS submessage deframer.
package rtpsd_pkg;

    localparam int PREFIX_BYTES = 12;
    localparam int HEADER_BYTES = 20;
    localparam int PREFIX_AT    = 8;
    localparam int SUBHDR_BYTES = 4;
    localparam int MAGIC_BYTES  = 4;

    localparam int POS_W  = 16;
    localparam int LEN_W  = 16;
    localparam int TDATA_W = 112;

    localparam logic [7:0] ID_INFO_DST  = 8'h0e;
    localparam logic [7:0] ID_HEARTBEAT = 8'h07;
    localparam logic [7:0] ID_DATA      = 8'h15;

    localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h52, 8'h54, 8'h50, 8'h53};

    typedef enum logic [1:0] {
        REG_RECEIVE_ENABLE    = 2'd0,
        REG_LOCAL_PREFIX_LOW  = 2'd1,
        REG_LOCAL_PREFIX_HIGH = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_SUBHDR   = 3'd1,
        PH_INFO_DST = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_WAIT     = 3'd4
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  payload;
        logic        kind;
        logic        last;
        logic [7:0]  flags;
        logic [31:0] prefix_high;
        logic [63:0] prefix_low;
    } result_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] prefix_high;
        logic [63:0] prefix_low;
    } cfg_t;

endpackage

// ===== design/rtpsd_parser.sv =====
// Per-byte packet and submessage parser: parse state and one step of logic.
module rtpsd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [7:0]         data_byte,
    input  logic               frame_end,
    input  rtpsd_pkg::cfg_t    cfg,
    output rtpsd_pkg::result_t result
);

    localparam int PW = rtpsd_pkg::POS_W;
    localparam int LW = rtpsd_pkg::LEN_W;

    rtpsd_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    flags_reg, flags_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    prefix_reg [rtpsd_pkg::PREFIX_BYTES];

    logic          prefix_we;
    logic [3:0]    prefix_idx;
    logic [95:0]   local_all;
    logic [7:0]    local_sel;
    logic [PW-1:0] pos_inc;
    logic          le;

    assign local_all = {cfg.prefix_high, cfg.prefix_low};
    assign pos_inc   = pos_reg + PW'(1);
    assign le        = flags_reg[0];
    assign prefix_idx = 4'(pos_reg[3:0] - 4'(rtpsd_pkg::PREFIX_AT));

    always_comb begin
        local_sel = 8'h00;
        for (int k = 0; k < rtpsd_pkg::PREFIX_BYTES; k++) begin
            if (pos_reg[3:0] == 4'(k)) begin
                local_sel = local_all[8*(rtpsd_pkg::PREFIX_BYTES-1-k) +: 8];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        flags_next = flags_reg;
        len_next   = len_reg;
        prefix_we  = 1'b0;
        result     = '0;
        for (int k = 0; k < 4; k++) begin
            result.prefix_high[8*(3-k) +: 8] = prefix_reg[k];
        end
        for (int k = 4; k < rtpsd_pkg::PREFIX_BYTES; k++) begin
            result.prefix_low[8*(rtpsd_pkg::PREFIX_BYTES-1-k) +: 8] = prefix_reg[k];
        end
        result.payload = data_byte;
        result.flags   = flags_reg;
        result.kind    = (id_reg == rtpsd_pkg::ID_DATA);

        unique case (phase_reg)
            rtpsd_pkg::PH_HEADER: begin
                if (pos_reg < PW'(rtpsd_pkg::MAGIC_BYTES) &&
                    data_byte != rtpsd_pkg::MAGIC[pos_reg[1:0]]) begin
                    phase_next = rtpsd_pkg::PH_WAIT;
                end else begin
                    prefix_we = (pos_reg >= PW'(rtpsd_pkg::PREFIX_AT)) &&
                                (pos_reg < PW'(rtpsd_pkg::PREFIX_AT + rtpsd_pkg::PREFIX_BYTES));
                    pos_next = pos_inc;
                    if (pos_inc >= PW'(rtpsd_pkg::HEADER_BYTES)) begin
                        pos_next   = '0;
                        phase_next = cfg.enable ? rtpsd_pkg::PH_SUBHDR : rtpsd_pkg::PH_WAIT;
                    end
                end
            end
            rtpsd_pkg::PH_SUBHDR: begin
                if (pos_reg == PW'(0)) begin
                    id_next = data_byte;
                end else if (pos_reg == PW'(1)) begin
                    flags_next = data_byte;
                end else if (pos_reg == PW'(2)) begin
                    len_next = le ? {8'h00, data_byte} : {data_byte, 8'h00};
                end else if (pos_reg == PW'(3)) begin
                    len_next = len_reg | (le ? {data_byte, 8'h00} : {8'h00, data_byte});
                end
                pos_next = pos_inc;
                if (pos_inc >= PW'(rtpsd_pkg::SUBHDR_BYTES)) begin
                    pos_next = '0;
                    if (len_next == '0) begin
                        phase_next = rtpsd_pkg::PH_SUBHDR;
                    end else if (id_next == rtpsd_pkg::ID_INFO_DST) begin
                        phase_next = rtpsd_pkg::PH_INFO_DST;
                    end else begin
                        phase_next = rtpsd_pkg::PH_PAYLOAD;
                    end
                end
            end
            rtpsd_pkg::PH_INFO_DST: begin
                if (pos_reg < PW'(rtpsd_pkg::PREFIX_BYTES) && data_byte != local_sel) begin
                    phase_next = rtpsd_pkg::PH_WAIT;
                end else begin
                    pos_next = pos_inc;
                    if (pos_inc == len_reg) begin
                        pos_next   = '0;
                        phase_next = rtpsd_pkg::PH_SUBHDR;
                    end
                end
            end
            rtpsd_pkg::PH_PAYLOAD: begin
                result.last = frame_end;
                pos_next    = pos_inc;
                if (pos_inc == len_reg) begin
                    pos_next    = '0;
                    phase_next  = rtpsd_pkg::PH_SUBHDR;
                    result.last = 1'b1;
                end
                result.valid = (id_reg == rtpsd_pkg::ID_HEARTBEAT) ||
                               (id_reg == rtpsd_pkg::ID_DATA);
            end
            default: begin
            end
        endcase

        if (frame_end) begin
            phase_next = rtpsd_pkg::PH_HEADER;
            pos_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rtpsd_pkg::PH_HEADER;
            pos_reg   <= '0;
            id_reg    <= '0;
            flags_reg <= '0;
            len_reg   <= '0;
            for (int k = 0; k < rtpsd_pkg::PREFIX_BYTES; k++) begin
                prefix_reg[k] <= '0;
            end
        end else if (step_en) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
            len_reg   <= len_next;
            for (int k = 0; k < rtpsd_pkg::PREFIX_BYTES; k++) begin
                if (prefix_we && prefix_idx == 4'(k)) begin
                    prefix_reg[k] <= data_byte;
                end
            end
        end
    end

endmodule

// ===== design/rtps_submessage_deframer.sv =====
// Top level of the RTPS submessage deframer: channels, config registers, stage registers.
//
// Channel   Direction  Handshake           Content
// s_        in         s_tvalid/s_tready   one packet byte, s_tlast on last byte
// m_        out        m_tvalid/m_tready   payload byte with kind, flags, source prefix
// cfg_      in         cfg_valid/cfg_ready register index and write data
//
// One byte per cycle sustained while m_ is not stalled; each byte passes through the input register
// and, when it is a forwarded payload byte, through the output register onto m_.
// The parse step runs when the input register is full and the output register is free
// or being taken, so a stall on m_ drops s_tready in the same cycle once the input
// register is full.
// aresetn is synchronous, active low, and returns parsing to the packet header.
module rtps_submessage_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  logic                          s_tlast,  // frame_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rtpsd_pkg::TDATA_W-1:0] m_tdata,  // [7:0] payload_byte, [15:8] submsg_flags,
                                                    // [47:16] source_prefix_high,
                                                    // [111:48] source_prefix_low
    output logic                          m_tuser,  // submsg_kind
    output logic                          m_tlast,  // last_byte
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [63:0]                   cfg_data
);

    rtpsd_pkg::cfg_t    cfg_reg;
    rtpsd_pkg::result_t res;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    logic                          out_valid_reg;
    logic [rtpsd_pkg::TDATA_W-1:0] out_data_reg;
    logic                          out_kind_reg;
    logic                          out_last_reg;

    logic step_en;

    assign cfg_ready = 1'b1;
    assign step_en   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_en;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rtpsd_pkg::REG_RECEIVE_ENABLE:    cfg_reg.enable      <= cfg_data[0];
                rtpsd_pkg::REG_LOCAL_PREFIX_LOW:  cfg_reg.prefix_low  <= cfg_data;
                rtpsd_pkg::REG_LOCAL_PREFIX_HIGH: cfg_reg.prefix_high <= cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rtpsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .data_byte (in_data_reg),
        .frame_end (in_last_reg),
        .cfg       (cfg_reg),
        .result    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res.valid) begin
            out_data_reg <= {res.prefix_low, res.prefix_high, res.flags, res.payload};
            out_kind_reg <= res.kind;
            out_last_reg <= res.last;
        end
    end

endmodule

// ===== design/rtpsd_checker.sv =====
// Port-level checks for the RTPS submessage deframer, bound to the top level.
module rtpsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rtpsd_pkg::TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("stage registers not empty after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a preceding input transaction");

endmodule

bind rtps_submessage_deframer rtpsd_checker u_checker (.*);

// ===== sim/rtps_submessage_deframer_tb.sv =====
// Self-checking testbench for rtps_submessage_deframer: packet stimulus, payload prediction.
`timescale 1ns / 1ps

module rtps_submessage_deframer_tb;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]  idx;
        logic [63:0] data;
    } reg_write_t;

    typedef struct packed {
        logic [7:0]  payload;
        logic        kind;
        logic        last;
        logic [7:0]  flags;
        logic [31:0] pfx_high;
        logic [63:0] pfx_low;
    } fwd_byte_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [rtpsd_pkg::TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = '0;
    logic [63:0]                   cfg_data  = '0;

    rx_item_t   rx_byte_q[$];
    reg_write_t reg_write_q[$];
    fwd_byte_t  fwd_expect_q[$];
    logic [7:0] frame_buf[$];

    int bytes_pending = 0;
    int bytes_sent    = 0;
    int cfg_pending   = 0;
    int err_count     = 0;
    int in_gap        = 0;
    int out_stall     = 0;
    bit calm          = 1'b0;

    // generator-side copy of the local prefix, byte 0 in the top bits
    logic [95:0] gen_local = '0;

    // deframer state as predicted
    logic              rx_enable = 1'b0;
    logic [95:0]       loc_pfx   = '0;
    rtpsd_pkg::phase_t phase     = rtpsd_pkg::PH_HEADER;
    logic [15:0]       pos       = '0;
    logic [7:0]        cur_id    = '0;
    logic [7:0]        cur_flags = '0;
    logic [15:0]       cur_len   = '0;
    logic [95:0]       src_pfx   = '0;

    rx_item_t   rx_next;
    reg_write_t reg_next;

    rtps_submessage_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_idle();
        if (calm || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic eop);
        logic le;
        logic lst;
        int   k;
        le  = cur_flags[0];
        lst = eop;
        case (phase)
            rtpsd_pkg::PH_HEADER: begin
                if (pos < rtpsd_pkg::MAGIC_BYTES && b != rtpsd_pkg::MAGIC[pos[1:0]]) begin
                    phase = rtpsd_pkg::PH_WAIT;
                end else begin
                    if (pos >= rtpsd_pkg::PREFIX_AT &&
                        pos < rtpsd_pkg::PREFIX_AT + rtpsd_pkg::PREFIX_BYTES) begin
                        k = pos - rtpsd_pkg::PREFIX_AT;
                        src_pfx[95 - 8 * k -: 8] = b;
                    end
                    pos++;
                    if (pos >= rtpsd_pkg::HEADER_BYTES) begin
                        pos   = '0;
                        phase = rx_enable ? rtpsd_pkg::PH_SUBHDR : rtpsd_pkg::PH_WAIT;
                    end
                end
            end
            rtpsd_pkg::PH_SUBHDR: begin
                case (pos)
                    16'd0: cur_id = b;
                    16'd1: cur_flags = b;
                    16'd2: cur_len = le ? {8'h00, b} : {b, 8'h00};
                    16'd3: cur_len = cur_len | (le ? {b, 8'h00} : {8'h00, b});
                    default: ;
                endcase
                pos++;
                if (pos >= rtpsd_pkg::SUBHDR_BYTES) begin
                    pos = '0;
                    if (cur_len == 0) phase = rtpsd_pkg::PH_SUBHDR;
                    else if (cur_id == rtpsd_pkg::ID_INFO_DST) phase = rtpsd_pkg::PH_INFO_DST;
                    else phase = rtpsd_pkg::PH_PAYLOAD;
                end
            end
            rtpsd_pkg::PH_INFO_DST: begin
                k = pos;
                if (pos < rtpsd_pkg::PREFIX_BYTES && b != loc_pfx[95 - 8 * k -: 8]) begin
                    phase = rtpsd_pkg::PH_WAIT;
                end else begin
                    pos++;
                    if (pos == cur_len) begin
                        pos   = '0;
                        phase = rtpsd_pkg::PH_SUBHDR;
                    end
                end
            end
            rtpsd_pkg::PH_PAYLOAD: begin
                pos++;
                if (pos == cur_len) begin
                    pos   = '0;
                    phase = rtpsd_pkg::PH_SUBHDR;
                    lst   = 1'b1;
                end
                if (cur_id == rtpsd_pkg::ID_HEARTBEAT || cur_id == rtpsd_pkg::ID_DATA)
                    fwd_expect_q.push_back('{payload: b,
                                             kind: (cur_id == rtpsd_pkg::ID_DATA),
                                             last: lst, flags: cur_flags,
                                             pfx_high: src_pfx[95:64],
                                             pfx_low: src_pfx[63:0]});
            end
            default: ;
        endcase
        if (eop) begin
            phase = rtpsd_pkg::PH_HEADER;
            pos   = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result();
        fwd_byte_t want;
        if (fwd_expect_q.size() == 0) begin
            $error("payload_byte: expected none, got %h", m_tdata[7:0]);
            err_count++;
        end else begin
            want = fwd_expect_q.pop_front();
            check_field("payload_byte", want.payload, m_tdata[7:0]);
            check_field("submsg_kind", want.kind, m_tuser);
            check_field("last_byte", want.last, m_tlast);
            check_field("submsg_flags", want.flags, m_tdata[15:8]);
            check_field("source_prefix_high", want.pfx_high, m_tdata[47:16]);
            check_field("source_prefix_low", want.pfx_low, m_tdata[111:48]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            in_gap    = 0;
            phase     = rtpsd_pkg::PH_HEADER;
            pos       = '0;
            cur_id    = '0;
            cur_flags = '0;
            cur_len   = '0;
            src_pfx   = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, s_tlast);
                bytes_pending--;
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (rx_byte_q.size() != 0) begin
                    rx_next = rx_byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_next.data;
                    s_tlast  <= rx_next.last;
                    in_gap   = draw_idle();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            out_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
                out_stall = draw_idle();
            end else if (out_stall > 0) begin
                out_stall--;
            end
            m_tready <= (out_stall == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
            rx_enable = 1'b0;
            loc_pfx   = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rtpsd_pkg::REG_RECEIVE_ENABLE:    rx_enable = cfg_data[0];
                    rtpsd_pkg::REG_LOCAL_PREFIX_LOW:  loc_pfx[63:0] = cfg_data;
                    rtpsd_pkg::REG_LOCAL_PREFIX_HIGH: loc_pfx[95:64] = cfg_data[31:0];
                    default: ;
                endcase
                cfg_pending--;
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_write_q.size() != 0) begin
                    reg_next = reg_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= reg_next.idx;
                    cfg_data  <= reg_next.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        reg_write_q.push_back('{idx: idx, data: data});
        cfg_pending++;
    endtask

    task automatic set_config(input bit en, input logic [95:0] pfx);
        write_reg(rtpsd_pkg::REG_RECEIVE_ENABLE, {$urandom, 31'($urandom), en});
        write_reg(rtpsd_pkg::REG_LOCAL_PREFIX_LOW, pfx[63:0]);
        write_reg(rtpsd_pkg::REG_LOCAL_PREFIX_HIGH, {$urandom, pfx[95:64]});
        gen_local = pfx;
        while (cfg_pending != 0) @(posedge aclk);
    endtask

    task automatic settle();
        int spins;
        spins = 0;
        while (bytes_pending != 0) @(posedge aclk);
        while (fwd_expect_q.size() != 0 && spins < 2000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic put_bytes(input int n);
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
    endtask

    task automatic put_header(input logic [95:0] pfx, input bit good);
        int bad;
        bad = good ? -1 : $urandom_range(0, rtpsd_pkg::MAGIC_BYTES - 1);
        for (int i = 0; i < rtpsd_pkg::MAGIC_BYTES; i++)
            frame_buf.push_back((i == bad) ?
                                rtpsd_pkg::MAGIC[i] ^ 8'($urandom_range(1, 255)) :
                                rtpsd_pkg::MAGIC[i]);
        put_bytes(rtpsd_pkg::PREFIX_AT - rtpsd_pkg::MAGIC_BYTES);
        for (int i = 0; i < rtpsd_pkg::PREFIX_BYTES; i++)
            frame_buf.push_back(pfx[95 - 8 * i -: 8]);
    endtask

    task automatic put_submsg(input logic [7:0] id, input logic [7:0] flags,
                              input logic [15:0] len);
        frame_buf.push_back(id);
        frame_buf.push_back(flags);
        frame_buf.push_back(flags[0] ? len[7:0] : len[15:8]);
        frame_buf.push_back(flags[0] ? len[15:8] : len[7:0]);
    endtask

    task automatic put_info_dst(input int len, input bit match);
        int         bad;
        logic [7:0] b;
        bad = match ? -1 :
              $urandom_range(0, (len < rtpsd_pkg::PREFIX_BYTES ?
                                 len : rtpsd_pkg::PREFIX_BYTES) - 1);
        put_submsg(rtpsd_pkg::ID_INFO_DST, 8'($urandom), 16'(len));
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i < rtpsd_pkg::PREFIX_BYTES) b = gen_local[95 - 8 * i -: 8];
            if (i == bad) b = b ^ 8'($urandom_range(1, 255));
            frame_buf.push_back(b);
        end
    endtask

    // keep <= 0 or beyond the frame ships the whole frame, otherwise the packet ends after keep bytes
    task automatic ship_frame(input int keep);
        int       n;
        rx_item_t it;
        n = (keep <= 0 || keep > frame_buf.size()) ? frame_buf.size() : keep;
        for (int i = 0; i < n; i++) begin
            it.data = frame_buf[i];
            it.last = (i == n - 1);
            rx_byte_q.push_back(it);
        end
        bytes_pending += n;
        bytes_sent    += n;
        frame_buf.delete();
    endtask

    function automatic int draw_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 16);
    endfunction

    task automatic random_frame();
        int         pick;
        int         len;
        logic [7:0] id;
        if ($urandom_range(0, 19) == 0) begin
            put_bytes($urandom_range(1, 40));
            ship_frame(0);
        end else begin
            put_header({$urandom, $urandom, $urandom}, $urandom_range(0, 19) != 0);
            repeat ($urandom_range(1, 5)) begin
                pick = $urandom_range(0, 99);
                len  = draw_len();
                if (pick < 30) begin
                    put_submsg(rtpsd_pkg::ID_HEARTBEAT, 8'($urandom), 16'(len));
                    put_bytes(len);
                end else if (pick < 60) begin
                    put_submsg(rtpsd_pkg::ID_DATA, 8'($urandom), 16'(len));
                    put_bytes(len);
                end else if (pick < 72) begin
                    put_info_dst($urandom_range(1, 20), 1'b1);
                end else if (pick < 77) begin
                    put_info_dst($urandom_range(1, 20), 1'b0);
                end else if (pick < 92) begin
                    do id = 8'($urandom);
                    while (id == rtpsd_pkg::ID_HEARTBEAT || id == rtpsd_pkg::ID_DATA ||
                           id == rtpsd_pkg::ID_INFO_DST);
                    put_submsg(id, 8'($urandom), 16'(len));
                    put_bytes(len);
                end else begin
                    put_submsg(8'($urandom), 8'($urandom), 16'd0);
                end
            end
            ship_frame($urandom_range(0, 6) == 0 ? $urandom_range(1, frame_buf.size()) : 0);
        end
    endtask

    task automatic random_phase(input int quota);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < quota) random_frame();
        settle();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // receive disabled out of reset: drop after the header
        put_header('0, 1'b1);
        put_submsg(rtpsd_pkg::ID_HEARTBEAT, 8'h00, 16'd2);
        put_bytes(2);
        ship_frame(0);
        settle();

        write_reg(REG_SPARE, {$urandom, $urandom});
        set_config(1'b1, 96'h0123_4567_89ab_cdef_fedc_ba98);

        // bad protocol bytes
        put_header({$urandom, $urandom, $urandom}, 1'b0);
        put_submsg(rtpsd_pkg::ID_DATA, 8'h00, 16'd1);
        put_bytes(1);
        ship_frame(0);

        // both kinds, both byte orders, zero length, skipped id, destination checks
        put_header('1, 1'b1);
        put_submsg(rtpsd_pkg::ID_HEARTBEAT, 8'h00, 16'd1);
        frame_buf.push_back(8'h00);
        put_submsg(rtpsd_pkg::ID_DATA, 8'hff, 16'd2);
        frame_buf.push_back(8'hff);
        frame_buf.push_back(8'h80);
        put_submsg(rtpsd_pkg::ID_DATA, 8'h01, 16'd0);
        put_submsg(8'h09, 8'h01, 16'd3);
        put_bytes(3);
        put_info_dst(12, 1'b1);
        put_info_dst(16, 1'b1);
        put_submsg(rtpsd_pkg::ID_HEARTBEAT, 8'hfe, 16'd3);
        put_bytes(3);
        put_info_dst(5, 1'b0);
        put_submsg(rtpsd_pkg::ID_DATA, 8'h00, 16'd2);
        put_bytes(2);
        ship_frame(0);

        // maximum length cut short by the end of the packet
        put_header('0, 1'b1);
        put_submsg(rtpsd_pkg::ID_DATA, 8'h01, 16'hffff);
        put_bytes(5);
        ship_frame(0);

        // packet ends inside the header, then inside a submessage header
        put_header({$urandom, $urandom, $urandom}, 1'b1);
        ship_frame(6);
        put_header({$urandom, $urandom, $urandom}, 1'b1);
        put_submsg(rtpsd_pkg::ID_HEARTBEAT, 8'h00, 16'd4);
        ship_frame(rtpsd_pkg::HEADER_BYTES + 2);
        put_header({$urandom, $urandom, $urandom}, 1'b1);
        put_submsg(rtpsd_pkg::ID_HEARTBEAT, 8'h01, 16'd2);
        put_bytes(2);
        ship_frame(0);
        settle();

        set_config(1'b1, {$urandom, $urandom, $urandom});
        random_phase(220);
        set_config(1'b1, '1);
        random_phase(190);
        set_config(1'b0, {$urandom, $urandom, $urandom});
        random_phase(80);
        calm = 1'b1;
        set_config(1'b1, '0);
        random_phase(190);
        calm = 1'b0;
        set_config(1'b1, {$urandom, $urandom, $urandom});
        random_phase(220);
        set_config(1'b1, {$urandom, $urandom, $urandom});
        random_phase(175);

        if (fwd_expect_q.size() != 0) begin
            $error("payload_byte: expected %0d more, got none", fwd_expect_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/rtpsd_pkg.sv
design/rtpsd_parser.sv
design/rtps_submessage_deframer.sv
design/rtpsd_checker.sv
sim/rtps_submessage_deframer_tb.sv
